@@ rtl/slt_pkg.sv @@
// Shared definitions for the sorted list table: operation and status codes,
// default sizes and the control bundle that drives the cell chain.
// No dependencies.
package slt_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int IN_VAL_W = 32;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic cmp_en;  // capture compare flags against the current key
    logic grow;    // open a slot at the insert point, shift upper part up
    logic shrink;  // close the slot at the match, shift upper part down
  } cell_ctl_t;

endpackage

@@ rtl/slt_cell.sv @@
// One storage cell of the sorted list table: holds one key, compares it with
// the broadcast key and shifts to or from its neighbors. Uses slt_pkg.
module slt_cell #(
  parameter int VALUE_BITS = slt_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  slt_pkg::cell_ctl_t    ctl,
  input  logic [VALUE_BITS-1:0] key,
  input  logic                  occ,
  input  logic                  lt_prev,
  input  logic [VALUE_BITS-1:0] left_entry,
  input  logic [VALUE_BITS-1:0] right_entry,
  output logic [VALUE_BITS-1:0] entry,
  output logic                  lt,
  output logic                  eq
);
  import slt_pkg::*;

  logic [VALUE_BITS-1:0] entry_r;
  logic                  lt_r;
  logic                  eq_r;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r <= occ && ($signed(entry_r) < $signed(key));
      eq_r <= occ && (entry_r == key);
    end
    if (ctl.grow) begin
      // above the insert point take the lower neighbor, at it take the key
      if (!lt_prev) begin
        entry_r <= left_entry;
      end else if (!lt_r) begin
        entry_r <= key;
      end
    end else if (ctl.shrink && !lt_r) begin
      entry_r <= right_entry;
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

@@ rtl/sorted_list_table.sv @@
// Top level of the sorted list table: stream ports, operation sequencer,
// entry count and the chain of slt_cell storage cells. Uses slt_pkg.
//
//  channel | ports                          | beat contents (low bit up)
//  --------+--------------------------------+---------------------------------
//  input   | in_tvalid/in_tready            | tdata: value[31:0]
//          | in_tdata[31:0], in_tuser[1:0]  | tuser: kind[1:0]
//  result  | out_tvalid/out_tready          | tdata: status[1:0], position[5:2],
//          | out_tdata[15:0]                |   entry_count[10:6], is_empty[11]
//
// Each operation runs accept, compare in every cell at once, then shift the
// chain and load the result register. The compare flags in the cells are
// registered, and only one item is in flight at a time.
// Reset clears the sequencer, entry count and result valid; cell contents
// stay undefined and are never read above the count. A stalled result
// blocks the next input beat until it is taken (or taken at that edge).
module sorted_list_table #(
  parameter int CAPACITY   = slt_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = slt_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status, position, entry_count, is_empty
);
  import slt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [KIND_W-1:0]     kind_r;
  logic [VALUE_BITS-1:0] key_r;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;

  logic                  in_fire;
  logic [63:0]           value_ext;
  cell_ctl_t             ctl;

  logic [VALUE_BITS-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]   lt_w, eq_w, occ_w, bound_w;
  logic                  found;
  logic                  full;
  logic [IDX_W-1:0]      bound_idx;
  logic [31:0]           pos_ext, cnt_ext;

  // Accept only when idle and the result register is free by the next edge.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // Sign-extend the 32-bit key, then fit it to the stored width.
  assign value_ext = 64'($signed(in_tdata));

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_tuser;
      key_r  <= value_ext[VALUE_BITS-1:0];
    end
  end

  // Cell chain: each cell sees its lower and upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  lt_prev;
    logic [VALUE_BITS-1:0] left_entry;
    logic [VALUE_BITS-1:0] right_entry;

    assign occ_w[i] = CNT_W'(i) < count_r;

    if (i == 0) begin : g_first
      assign lt_prev    = 1'b1;
      assign left_entry = key_r;
    end else begin : g_mid
      assign lt_prev    = lt_w[i-1];
      assign left_entry = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_upper
      assign right_entry = entry_w[i+1];
    end

    // The first cell not below the key marks the insert or match point.
    assign bound_w[i] = !lt_w[i] && lt_prev;

    slt_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (key_r),
      .occ         (occ_w[i]),
      .lt_prev     (lt_prev),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_w[i]),
      .lt          (lt_w[i]),
      .eq          (eq_w[i])
    );
  end

  // One-hot boundary to index; cells are independent terms of the OR.
  always_comb begin
    bound_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bound_w[i]) begin
        bound_idx = bound_idx | IDX_W'(i);
      end
    end
  end

  assign found = |(bound_w & eq_w);
  assign full  = count_r == CNT_W'(CAPACITY);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    ctl           = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.cmp_en = 1'b1;
        state_nxt  = S_APPLY;
      end
      S_APPLY: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        status_nxt    = ST_MISSING;
        pos_nxt       = '0;
        case (kind_r)
          KIND_INSERT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ctl.grow   = 1'b1;
              count_nxt  = count_r + 1'b1;
              status_nxt = ST_DONE;
              pos_nxt    = bound_idx;
            end
          end
          KIND_DELETE: begin
            if (found) begin
              ctl.shrink = 1'b1;
              count_nxt  = count_r - 1'b1;
              status_nxt = ST_DONE;
              pos_nxt    = bound_idx;
            end
          end
          KIND_LOOKUP: begin
            if (found) begin
              status_nxt = ST_DONE;
              pos_nxt    = bound_idx;
            end
          end
          default: begin
            status_nxt = ST_MISSING;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and count snapshot only change when a result is loaded.
  logic [CNT_W-1:0] res_count_r;

  always_ff @(posedge clk) begin
    if (state_r == S_APPLY) begin
      status_r    <= status_nxt;
      pos_r       <= pos_nxt;
      res_count_r <= count_nxt;
    end
  end

  assign pos_ext = 32'(pos_r);
  assign cnt_ext = 32'(res_count_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       (res_count_r == '0),
                       cnt_ext[COUNT_W-1:0],
                       pos_ext[POS_W-1:0],
                       status_r};

endmodule
